// ===== design/cln_pkg.sv =====
// shared types, codes and event tables for the character lcd nibble sequencer
// no dependencies; every design file imports this package
package cln_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_INIT  = 2'd1,
        CMD_GOTO  = 2'd2,
        CMD_NONE  = 2'd3
    } cln_cmd_t;

    typedef struct packed {
        cln_cmd_t    cmd;
        logic [7:0]  data_byte;
        logic        reg_select;
        logic [1:0]  row;
        logic [5:0]  col;
    } cln_in_item_t;

    typedef struct packed {
        logic        rs_pin;
        logic        enable_pin;
        logic [3:0]  nibble_out;
        logic [15:0] wait_us;
        logic        last;
    } cln_out_item_t;

    typedef struct packed {
        logic       is_init;
        logic [7:0] byte_val;
        logic       rs;
    } cln_job_t;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic full;
        logic empty;
    } cln_q_status_t;

    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_PREFIX = 2'd1,
        BK_BYTE   = 2'd2
    } cln_back_state_t;

    localparam logic [15:0] WAIT_E_HIGH   = 16'd1;
    localparam logic [15:0] WAIT_E_LOW    = 16'd50;
    localparam logic [15:0] WAIT_TAIL     = 16'd100;
    localparam logic [15:0] WAIT_TAIL_SLOW = 16'd2100;
    localparam logic [15:0] WAIT_POWER_UP = 16'd50000;
    localparam logic [15:0] WAIT_INIT_1ST = 16'd5050;
    localparam logic [15:0] WAIT_INIT_NXT = 16'd200;

    localparam logic [7:0] INSTR_CLEAR = 8'h01;
    localparam logic [7:0] INSTR_HOME  = 8'h02;
    localparam logic [7:0] LCD_SET_DDR = 8'h80;
    localparam logic [3:0] NIB_WAKE    = 4'h3;
    localparam logic [3:0] NIB_4BIT    = 4'h2;
    localparam logic [3:0] PREFIX_LAST = 4'd8;
    localparam logic [1:0] SUB_LAST    = 2'd3;
    localparam logic [1:0] INIT_CMD_LAST = 2'd3;

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] base;
        case (row)
            2'd0:    base = 8'h00;
            2'd1:    base = 8'h40;
            2'd2:    base = 8'h14;
            2'd3:    base = 8'h54;
            default: base = 8'h00;
        endcase
        return base;
    endfunction

    function automatic logic [7:0] init_cmd(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h28;
            2'd1:    c = 8'h0C;
            2'd2:    c = 8'h01;
            2'd3:    c = 8'h06;
            default: c = 8'h28;
        endcase
        return c;
    endfunction

    // power-up wait then the wake-up nibbles
    function automatic cln_out_item_t prefix_event(input logic [3:0] step);
        cln_out_item_t ev;
        ev.rs_pin = 1'b0;
        ev.last   = 1'b0;
        if (step == 4'd0) begin
            ev.enable_pin = 1'b0;
            ev.nibble_out = 4'h0;
            ev.wait_us    = WAIT_POWER_UP;
        end else begin
            ev.enable_pin = step[0];
            ev.nibble_out = (step == 4'd7 || step == 4'd8) ? NIB_4BIT : NIB_WAKE;
            if (step[0]) begin
                ev.wait_us = WAIT_E_HIGH;
            end else if (step == 4'd2) begin
                ev.wait_us = WAIT_INIT_1ST;
            end else begin
                ev.wait_us = WAIT_INIT_NXT;
            end
        end
        return ev;
    endfunction

    function automatic cln_out_item_t byte_event(input logic [7:0] value, input logic rs,
                                                 input logic [1:0] sub);
        cln_out_item_t ev;
        ev.rs_pin     = rs;
        ev.enable_pin = ~sub[0];
        ev.nibble_out = sub[1] ? value[3:0] : value[7:4];
        ev.last       = 1'b0;
        case (sub)
            2'd0:    ev.wait_us = WAIT_E_HIGH;
            2'd1:    ev.wait_us = WAIT_E_LOW;
            2'd2:    ev.wait_us = WAIT_E_HIGH;
            2'd3:    ev.wait_us = (!rs && (value == INSTR_CLEAR || value == INSTR_HOME))
                                  ? WAIT_TAIL_SLOW : WAIT_TAIL;
            default: ev.wait_us = WAIT_E_HIGH;
        endcase
        return ev;
    endfunction

endpackage

// ===== design/cln_front.sv =====
// request decoder: accepts requests and turns them into byte or init jobs
// depends on cln_pkg
module cln_front (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  cln_pkg::cln_in_item_t s_data,
    input  cln_pkg::cln_q_status_t q_stat,
    output logic                  push,
    output cln_pkg::cln_job_t     push_job
);
    import cln_pkg::*;

    logic [7:0] goto_addr;

    assign s_ready   = ~q_stat.full;
    assign push      = s_valid && s_ready && (s_data.cmd != CMD_NONE);
    assign goto_addr = row_base(s_data.row) + {2'b00, s_data.col};

    always_comb begin
        push_job.is_init  = 1'b0;
        push_job.byte_val = s_data.data_byte;
        push_job.rs       = s_data.reg_select;
        case (s_data.cmd)
            CMD_WRITE: begin
                push_job.is_init = 1'b0;
            end
            CMD_INIT: begin
                push_job.is_init = 1'b1;
                push_job.rs      = 1'b0;
            end
            CMD_GOTO: begin
                push_job.byte_val = LCD_SET_DDR | goto_addr;
                push_job.rs       = 1'b0;
            end
            default: begin
                push_job.is_init = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/cln_queue.sv =====
// small job fifo between the request decoder and the event sequencer
// depends on cln_pkg
module cln_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  cln_pkg::cln_job_t      push_job,
    input  logic                   pop,
    output cln_pkg::cln_job_t      head,
    output cln_pkg::cln_q_status_t q_stat
);
    import cln_pkg::*;

    cln_job_t          slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QDEPTH - 1);
    localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QDEPTH);

    assign q_stat.full  = (count_reg == CNT_FULL);
    assign q_stat.empty = (count_reg == '0);
    assign head         = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== design/cln_back.sv =====
// event sequencer: steps through the pin events of one job into an output register
// depends on cln_pkg
module cln_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cln_pkg::cln_job_t      head,
    input  cln_pkg::cln_q_status_t q_stat,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output cln_pkg::cln_out_item_t m_data
);
    import cln_pkg::*;

    cln_back_state_t state_reg, state_next;
    logic [3:0]      step_reg, step_next;
    logic [1:0]      sub_reg, sub_next;
    logic [1:0]      idx_reg, idx_next;
    cln_job_t        job_reg, job_next;
    logic            m_valid_reg, m_valid_next;
    cln_out_item_t   m_data_reg, m_data_next;

    cln_out_item_t   ev;
    logic [7:0]      cur_byte;
    logic            cur_rs;
    logic            is_last;
    logic            out_load;

    // event selection
    always_comb begin
        cur_byte = job_reg.is_init ? init_cmd(idx_reg) : job_reg.byte_val;
        cur_rs   = job_reg.is_init ? 1'b0 : job_reg.rs;
        is_last  = (state_reg == BK_BYTE) && (sub_reg == SUB_LAST)
                   && (!job_reg.is_init || idx_reg == INIT_CMD_LAST);
        out_load = (state_reg != BK_IDLE) && (!m_valid_reg || m_ready);
        pop      = !q_stat.empty && ((state_reg == BK_IDLE) || (out_load && is_last));
        case (state_reg)
            BK_PREFIX: ev = prefix_event(step_reg);
            BK_BYTE:   ev = byte_event(cur_byte, cur_rs, sub_reg);
            default:   ev = byte_event(cur_byte, cur_rs, sub_reg);
        endcase
        ev.last = is_last;
    end

    // next state
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        sub_next     = sub_reg;
        idx_next     = idx_reg;
        job_next     = job_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = ev;
            case (state_reg)
                BK_PREFIX: begin
                    if (step_reg == PREFIX_LAST) begin
                        state_next = BK_BYTE;
                        sub_next   = '0;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
                BK_BYTE: begin
                    if (sub_reg == SUB_LAST) begin
                        sub_next = '0;
                        if (is_last) begin
                            state_next = BK_IDLE;
                        end else begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end else begin
                        sub_next = sub_reg + 1'b1;
                    end
                end
                default: begin
                    state_next = BK_IDLE;
                end
            endcase
        end
        if (pop) begin
            job_next   = head;
            state_next = head.is_init ? BK_PREFIX : BK_BYTE;
            step_next  = '0;
            sub_next   = '0;
            idx_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            step_reg    <= '0;
            sub_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            sub_reg     <= sub_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/char_lcd_nibble_sequencer.sv =====
// top level of the character lcd nibble sequencer
// depends on cln_pkg, cln_front, cln_queue and cln_back
//
// usage:
//   s_ channel takes one request per beat: write byte, run init, or goto
//   row and column. m_ channel gives one pin event per beat (rs, e, data
//   nibble, hold time in us, last). the receiver plays the events out.
//   a write or goto request gives 4 events, init gives 25, cmd 3 gives none
//   and is simply dropped.
//   a request passes the job queue and the job register before its first
//   event is loaded into the output register. events follow one per cycle
//   while m_ready is high; the sequencer picks up the next queued job in the
//   cycle its last event is loaded, so back-to-back writes run with no gaps.
//   a two-entry job queue sits between the decoder and the sequencer;
//   s_ready drops only when that queue is full.
//   when m_ready is low the output register holds its event and the
//   sequencer waits; requests keep entering until the queue fills.
//   reset (aresetn low, synchronous) empties the queue and idles the
//   sequencer; no result is pending afterwards.
module char_lcd_nibble_sequencer (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  cln_pkg::cln_in_item_t  s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output cln_pkg::cln_out_item_t m_data
);
    import cln_pkg::*;

    cln_q_status_t q_stat;
    cln_job_t      push_job;
    cln_job_t      head;
    logic          push;
    logic          pop;

    cln_front u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    cln_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    cln_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .q_stat  (q_stat),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef NO_ASSERTIONS
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_stat.full)
        else $error("s_ready low with room in job queue");

    a_last_is_e_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last |-> !m_data.enable_pin)
        else $error("last event with enable high");

    a_e_high_short: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.enable_pin |-> m_data.wait_us == WAIT_E_HIGH)
        else $error("enable-high event with wrong hold time");

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("job taken from empty queue");
`endif

endmodule

// ===== verif/char_lcd_nibble_sequencer_tb.sv =====
// self-checking testbench for char_lcd_nibble_sequencer: lcd requests in, pin events out
// needs design/cln_pkg.sv and the sequencer rtl; predicted or typed events check each m_ beat
// directed table first, then random requests under three sender/receiver idling mixes
module char_lcd_nibble_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cln_pkg::*;

    localparam logic [15:0] HOLD_E_HIGH     = 16'd1;
    localparam logic [15:0] HOLD_E_LOW      = 16'd50;
    localparam logic [15:0] HOLD_TAIL_EXTRA = 16'd50;
    localparam logic [15:0] HOLD_SLOW_INSTR = 16'd2000;
    localparam logic [15:0] HOLD_POWER_ON   = 16'd50000;
    localparam logic [15:0] HOLD_WAKE_FIRST = 16'd5000;
    localparam logic [15:0] HOLD_WAKE_NEXT  = 16'd150;
    localparam logic [3:0]  WAKE_NIBBLE     = 4'h3;
    localparam logic [3:0]  FOUR_BIT_NIBBLE = 4'h2;
    localparam int          STALL_LIMIT     = 2000;
    localparam int          DRAIN_CYCLES    = 20;
    localparam int          MAX_REPORTS     = 10;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    cln_in_item_t  s_data = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    cln_out_item_t m_data;

    cln_out_item_t pin_events_due[$];
    cln_out_item_t pin_burst[$];
    cln_in_item_t  dir_reqs[$];
    int            dir_typed[$];
    cln_out_item_t dir_events[$];

    logic [7:0] ddram_row_base [4] = '{8'h00, 8'h40, 8'h14, 8'h54};
    logic [7:0] boot_instr [4] = '{8'h28, 8'h0C, 8'h01, 8'h06};

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int pin_mismatches = 0;
    int quiet_cycles = 0;

    char_lcd_nibble_sequencer u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic cln_out_item_t pin(logic rs, logic e, logic [3:0] nib, logic [15:0] hold,
                                          logic fin);
        cln_out_item_t p;
        p.rs_pin     = rs;
        p.enable_pin = e;
        p.nibble_out = nib;
        p.wait_us    = hold;
        p.last       = fin;
        return p;
    endfunction

    function automatic cln_in_item_t req(cln_cmd_t c, logic [7:0] d, logic rs, logic [1:0] r,
                                         logic [5:0] cl);
        cln_in_item_t q;
        q.cmd        = c;
        q.data_byte  = d;
        q.reg_select = rs;
        q.row        = r;
        q.col        = cl;
        return q;
    endfunction

    function automatic void burst_nibble(logic rs, logic [3:0] nib, logic [15:0] low_hold);
        pin_burst.push_back(pin(rs, 1'b1, nib, HOLD_E_HIGH, 1'b0));
        pin_burst.push_back(pin(rs, 1'b0, nib, low_hold, 1'b0));
    endfunction

    function automatic void burst_byte(logic [7:0] value, logic rs);
        logic [15:0] tail;
        tail = HOLD_E_LOW + HOLD_TAIL_EXTRA;
        if (!rs && (value == INSTR_CLEAR || value == INSTR_HOME)) begin
            tail = tail + HOLD_SLOW_INSTR;
        end
        burst_nibble(rs, value[7:4], HOLD_E_LOW);
        burst_nibble(rs, value[3:0], tail);
    endfunction

    function automatic void predict_pin_events(cln_in_item_t r);
        logic [7:0]    addr;
        cln_out_item_t tail_ev;
        pin_burst.delete();
        case (r.cmd)
            CMD_WRITE: begin
                burst_byte(r.data_byte, r.reg_select);
            end
            CMD_INIT: begin
                pin_burst.push_back(pin(1'b0, 1'b0, 4'h0, HOLD_POWER_ON, 1'b0));
                burst_nibble(1'b0, WAKE_NIBBLE, HOLD_E_LOW + HOLD_WAKE_FIRST);
                burst_nibble(1'b0, WAKE_NIBBLE, HOLD_E_LOW + HOLD_WAKE_NEXT);
                burst_nibble(1'b0, WAKE_NIBBLE, HOLD_E_LOW + HOLD_WAKE_NEXT);
                burst_nibble(1'b0, FOUR_BIT_NIBBLE, HOLD_E_LOW + HOLD_WAKE_NEXT);
                for (int i = 0; i < 4; i++) begin
                    burst_byte(boot_instr[i], 1'b0);
                end
            end
            CMD_GOTO: begin
                addr = ddram_row_base[r.row] + {2'b00, r.col};
                burst_byte(LCD_SET_DDR | addr, 1'b0);
            end
            default: begin
            end
        endcase
        if (pin_burst.size() > 0) begin
            tail_ev = pin_burst.pop_back();
            tail_ev.last = 1'b1;
            pin_burst.push_back(tail_ev);
        end
        foreach (pin_burst[i]) begin
            pin_events_due.push_back(pin_burst[i]);
        end
    endfunction

    function automatic cln_in_item_t random_req();
        cln_in_item_t r;
        int pick;
        r = req(CMD_WRITE, 8'($urandom), 1'($urandom), 2'($urandom), 6'($urandom));
        if ($urandom_range(0, 9) == 0) begin
            r.col = 6'($urandom_range(40, 63));
        end else begin
            r.col = 6'($urandom_range(0, 39));
        end
        if ($urandom_range(0, 7) == 0) begin
            r.data_byte = $urandom_range(0, 1) ? INSTR_CLEAR : INSTR_HOME;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            r.cmd = CMD_WRITE;
        end else if (pick < 80) begin
            r.cmd = CMD_GOTO;
        end else if (pick < 90) begin
            r.cmd = CMD_INIT;
        end else begin
            r.cmd = CMD_NONE;
        end
        return r;
    endfunction

    task automatic send_req(cln_in_item_t r, int typed_n);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (typed_n < 0) begin
            predict_pin_events(r);
        end else begin
            repeat (typed_n) pin_events_due.push_back(dir_events.pop_front());
        end
    endtask

    task automatic send_random(int n);
        cln_in_item_t r;
        int sent;
        sent = 0;
        while (sent < n) begin
            r = random_req();
            send_req(r, -1);
            if (r.cmd != CMD_NONE) sent++;
        end
    endtask

    task automatic add_row(cln_in_item_t r, int typed_n);
        dir_reqs.push_back(r);
        dir_typed.push_back(typed_n);
    endtask

    // result side: random stalls and the beat checker
    always @(posedge aclk) begin
        cln_out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (m_valid && m_ready) begin
                if (pin_events_due.size() == 0) begin
                    pin_mismatches++;
                    if (pin_mismatches <= MAX_REPORTS) begin
                        $display("unexpected pin event: rs=%0d e=%0d nib=%h wait=%0d last=%0d",
                                 m_data.rs_pin, m_data.enable_pin, m_data.nibble_out,
                                 m_data.wait_us, m_data.last);
                    end
                end else begin
                    want = pin_events_due.pop_front();
                    if (m_data.rs_pin !== want.rs_pin || m_data.enable_pin !== want.enable_pin
                        || m_data.nibble_out !== want.nibble_out
                        || m_data.wait_us !== want.wait_us || m_data.last !== want.last) begin
                        pin_mismatches++;
                        if (pin_mismatches <= MAX_REPORTS) begin
                            $display("pin event mismatch: exp rs=%0d e=%0d nib=%h wait=%0d last=%0d",
                                     want.rs_pin, want.enable_pin, want.nibble_out,
                                     want.wait_us, want.last);
                            $display("                    got rs=%0d e=%0d nib=%h wait=%0d last=%0d",
                                     m_data.rs_pin, m_data.enable_pin, m_data.nibble_out,
                                     m_data.wait_us, m_data.last);
                        end
                    end
                end
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        add_row(req(CMD_WRITE, 8'h00, 1'b0, 2'd3, 6'h3F), 4);
        dir_events.push_back(pin(1'b0, 1'b1, 4'h0, 16'd1, 1'b0));
        dir_events.push_back(pin(1'b0, 1'b0, 4'h0, 16'd50, 1'b0));
        dir_events.push_back(pin(1'b0, 1'b1, 4'h0, 16'd1, 1'b0));
        dir_events.push_back(pin(1'b0, 1'b0, 4'h0, 16'd100, 1'b1));
        add_row(req(CMD_WRITE, 8'hFF, 1'b1, 2'd0, 6'h00), 4);
        dir_events.push_back(pin(1'b1, 1'b1, 4'hF, 16'd1, 1'b0));
        dir_events.push_back(pin(1'b1, 1'b0, 4'hF, 16'd50, 1'b0));
        dir_events.push_back(pin(1'b1, 1'b1, 4'hF, 16'd1, 1'b0));
        dir_events.push_back(pin(1'b1, 1'b0, 4'hF, 16'd100, 1'b1));
        add_row(req(CMD_WRITE, INSTR_CLEAR, 1'b0, 2'd0, 6'h00), 4);
        dir_events.push_back(pin(1'b0, 1'b1, 4'h0, 16'd1, 1'b0));
        dir_events.push_back(pin(1'b0, 1'b0, 4'h0, 16'd50, 1'b0));
        dir_events.push_back(pin(1'b0, 1'b1, 4'h1, 16'd1, 1'b0));
        dir_events.push_back(pin(1'b0, 1'b0, 4'h1, 16'd2100, 1'b1));
        add_row(req(CMD_WRITE, INSTR_HOME, 1'b0, 2'd2, 6'h2A), 4);
        dir_events.push_back(pin(1'b0, 1'b1, 4'h0, 16'd1, 1'b0));
        dir_events.push_back(pin(1'b0, 1'b0, 4'h0, 16'd50, 1'b0));
        dir_events.push_back(pin(1'b0, 1'b1, 4'h2, 16'd1, 1'b0));
        dir_events.push_back(pin(1'b0, 1'b0, 4'h2, 16'd2100, 1'b1));
        add_row(req(CMD_WRITE, INSTR_CLEAR, 1'b1, 2'd1, 6'h15), -1);
        add_row(req(CMD_WRITE, INSTR_HOME, 1'b1, 2'd0, 6'h00), -1);
        add_row(req(CMD_WRITE, 8'h03, 1'b0, 2'd0, 6'h00), -1);
        add_row(req(CMD_WRITE, 8'hA5, 1'b1, 2'd2, 6'h2A), -1);
        add_row(req(CMD_WRITE, 8'h5A, 1'b0, 2'd1, 6'h15), -1);
        add_row(req(CMD_NONE, 8'hFF, 1'b1, 2'd3, 6'h3F), 0);
        add_row(req(CMD_INIT, 8'h00, 1'b0, 2'd0, 6'h00), -1);
        add_row(req(CMD_INIT, 8'hFF, 1'b1, 2'd3, 6'h3F), -1);
        for (int r = 0; r < 4; r++) begin
            add_row(req(CMD_GOTO, 8'h00, 1'b0, 2'(r), 6'd0), -1);
            add_row(req(CMD_GOTO, 8'hFF, 1'b1, 2'(r), 6'd39), -1);
        end
        // column past the row end, highest address reachable
        add_row(req(CMD_GOTO, 8'h00, 1'b0, 2'd3, 6'd63), 4);
        dir_events.push_back(pin(1'b0, 1'b1, 4'h9, 16'd1, 1'b0));
        dir_events.push_back(pin(1'b0, 1'b0, 4'h9, 16'd50, 1'b0));
        dir_events.push_back(pin(1'b0, 1'b1, 4'h3, 16'd1, 1'b0));
        dir_events.push_back(pin(1'b0, 1'b0, 4'h3, 16'd100, 1'b1));
        add_row(req(CMD_GOTO, 8'hFF, 1'b1, 2'd1, 6'd63), -1);
        add_row(req(CMD_NONE, 8'h00, 1'b0, 2'd0, 6'h00), 0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 33;
        recv_idle_pct = 79;
        foreach (dir_reqs[i]) begin
            send_req(dir_reqs[i], dir_typed[i]);
        end
        send_random(25);
        send_idle_pct = 79;
        recv_idle_pct = 33;
        send_random(25);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(25);
        s_valid <= 1'b0;

        while (pin_events_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pin_mismatches == 0 && pin_events_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
